FILE: rtl/mss_pkg.sv
package mss_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int CMP_W        = 9;
   localparam int INV_W        = 11;
   localparam int STACK_DEPTH  = 8;
   localparam int SP_W         = $clog2(STACK_DEPTH);

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_res;
      logic [CMP_W-1:0]   comparisons;
      logic [INV_W-1:0]   inversions;
      logic               overflow;
   } rsp_type;

   // Progress of one range on the recursion stack.
   typedef enum logic [1:0] {
      PH_NEW  = 2'd0,
      PH_LEFT = 2'd1,
      PH_BOTH = 2'd2
   } phase_type;

   typedef struct packed {
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
      phase_type        phase;
   } range_type;

   typedef struct packed {
      logic      load;
      logic      push;
      logic      pop;
      phase_type phase;
      range_type entry;
   } stack_ctl_type;

endpackage

FILE: rtl/mss_stack.sv
module mss_stack
   import mss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stack_ctl_type ctl,
   output range_type     top,
   output logic          empty
);

   range_type            top_ff;
   range_type            top_in;
   logic [SP_W-1:0]      sp_ff;
   logic [SP_W-1:0]      sp_in;
   range_type            stack_mem [STACK_DEPTH];

   // The top range lives in a register; the ranges below it live in the array.
   always_comb begin
      top_in = top_ff;
      sp_in  = sp_ff;
      priority if (ctl.load) begin
         top_in = ctl.entry;
         sp_in  = '0;
      end else if (ctl.push) begin
         top_in = ctl.entry;
         sp_in  = sp_ff + 1'b1;
      end else if (ctl.pop) begin
         top_in = stack_mem[sp_ff - 1'b1];
         sp_in  = sp_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (ctl.push && !ctl.load) begin
         stack_mem[sp_ff] <= '{lo: top_ff.lo, hi: top_ff.hi, phase: ctl.phase};
      end
   end

   assign top   = top_ff;
   assign empty = (sp_ff == '0);

   // A push must find room and a pop must find an entry.
   assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> (sp_ff != SP_W'(STACK_DEPTH - 1))) else $error("stack overflow");
   assert property (@(posedge clock) disable iff (reset)
      (ctl.pop && !ctl.load) |-> (sp_ff != '0)) else $error("stack underflow");
   assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.pop)) else $error("push and pop together");

endmodule

FILE: rtl/merge_sorter_with_statistics_unit.sv
// Merge sorter with statistics.
// Input channel req_*: one signed element per transaction; last marks the
// final element of an array. Up to 64 elements are held; further elements
// are dropped and the overflow flag of the run is set.
// After the last element the block sorts the array ascending with a stable
// top-down merge sort and then emits one rsp_* transaction per element, in
// order, with last_res on the final one. Every result carries the merge
// comparison count and the inversion count of the arrival order.
// Loading accepts one element per cycle while req_ready is high. Sorting walks
// the recursion with a small range stack and merges through one element memory
// with two read ports and one scratch memory: each merged element is read in
// ST_MRD and written to scratch in ST_MWR, and each copied element is read in
// ST_CRD and written back in ST_CWR. Each result is read from the element
// memory in ST_ORD and then offered in ST_OUT, one read per result.
// req_ready is low while sorting and emitting. When the receiver stalls the
// result is held unchanged on rsp_data until it is taken.
// Reset (synchronous) empties the block; no clearing pass is needed.
module merge_sorter_with_statistics_unit
   import mss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [7:0] {
      ST_LOAD  = 8'b0000_0001,
      ST_SCHED = 8'b0000_0010,
      ST_MRD   = 8'b0000_0100,
      ST_MWR   = 8'b0000_1000,
      ST_CRD   = 8'b0001_0000,
      ST_CWR   = 8'b0010_0000,
      ST_ORD   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CMP_W-1:0]   cmp_ff, cmp_in;
   logic [INV_W-1:0]   inv_ff, inv_in;
   logic [CNT_W-1:0]   a_ff, a_in;
   logic [CNT_W-1:0]   b_ff, b_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   // Memories and their ports.
   logic signed [31:0] store_mem [MAX_ELEMENTS];
   logic signed [31:0] scratch_mem [MAX_ELEMENTS];
   logic               st_we, st_re, sc_we, sc_re;
   logic [IDX_W-1:0]   st_waddr, st_raddr_a, st_raddr_b;
   logic signed [31:0] st_wdata, sc_wdata;
   logic signed [31:0] st_rd_a_ff, st_rd_b_ff, sc_rd_ff;

   stack_ctl_type      stk_ctl;
   range_type          stk_top;
   logic               stk_empty;

   logic               req_fire, rsp_fire;
   logic               avail_a, avail_b, take_a;
   logic [CNT_W-1:0]   mid_sum, n_words;
   logic [IDX_W-1:0]   top_mid;

   mss_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .top   (stk_top),
      .empty (stk_empty)
   );

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign mid_sum = {1'b0, stk_top.lo} + {1'b0, stk_top.hi};
   assign top_mid = mid_sum[IDX_W:1];
   assign avail_a = (a_ff <= {1'b0, mid_ff});
   assign avail_b = (b_ff <= {1'b0, hi_ff});
   assign take_a  = avail_a && (!avail_b || (st_rd_a_ff <= st_rd_b_ff));
   assign n_words = (count_ff < CNT_W'(MAX_ELEMENTS)) ? count_ff + 1'b1 : count_ff;

   // Main sequencer: load, walk the ranges, merge, copy back, emit.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      cmp_in     = cmp_ff;
      inv_in     = inv_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      lo_in      = lo_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      idx_in     = idx_ff;
      st_we      = 1'b0;
      st_waddr   = count_ff[IDX_W-1:0];
      st_wdata   = req_data.value;
      st_re      = 1'b0;
      st_raddr_a = a_ff[IDX_W-1:0];
      st_raddr_b = b_ff[IDX_W-1:0];
      sc_we      = 1'b0;
      sc_wdata   = take_a ? st_rd_a_ff : st_rd_b_ff;
      sc_re      = 1'b0;
      stk_ctl    = '0;
      stk_ctl.entry = '{lo: '0, hi: '0, phase: PH_NEW};
      stk_ctl.phase = PH_NEW;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < CNT_W'(MAX_ELEMENTS)) begin
                  st_we    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  stk_ctl.load  = 1'b1;
                  stk_ctl.entry = '{lo: '0, hi: IDX_W'(n_words - 1'b1), phase: PH_NEW};
                  state_in      = ST_SCHED;
               end
            end
         end
         ST_SCHED: begin
            if (stk_top.lo >= stk_top.hi) begin
               if (stk_empty) begin
                  idx_in   = '0;
                  state_in = ST_ORD;
               end else begin
                  stk_ctl.pop = 1'b1;
               end
            end else begin
               unique case (stk_top.phase)
                  PH_NEW: begin
                     stk_ctl.push  = 1'b1;
                     stk_ctl.phase = PH_LEFT;
                     stk_ctl.entry = '{lo: stk_top.lo, hi: top_mid, phase: PH_NEW};
                  end
                  PH_LEFT: begin
                     stk_ctl.push  = 1'b1;
                     stk_ctl.phase = PH_BOTH;
                     stk_ctl.entry = '{lo: top_mid + 1'b1, hi: stk_top.hi, phase: PH_NEW};
                  end
                  default: begin
                     a_in     = {1'b0, stk_top.lo};
                     b_in     = {1'b0, top_mid} + 1'b1;
                     k_in     = stk_top.lo;
                     lo_in    = stk_top.lo;
                     mid_in   = top_mid;
                     hi_in    = stk_top.hi;
                     state_in = ST_MRD;
                  end
               endcase
            end
         end
         ST_MRD: begin
            st_re    = 1'b1;
            state_in = ST_MWR;
         end
         ST_MWR: begin
            // Take one element; a right-side element passes every left one left.
            sc_we = 1'b1;
            if (avail_a && avail_b) begin
               cmp_in = cmp_ff + 1'b1;
            end
            if (take_a) begin
               a_in = a_ff + 1'b1;
            end else begin
               b_in = b_ff + 1'b1;
               if (avail_a) begin
                  inv_in = inv_ff + INV_W'({1'b0, mid_ff} - a_ff + 1'b1);
               end
            end
            if (k_ff == hi_ff) begin
               k_in     = lo_ff;
               state_in = ST_CRD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_MRD;
            end
         end
         ST_CRD: begin
            sc_re    = 1'b1;
            state_in = ST_CWR;
         end
         ST_CWR: begin
            st_we    = 1'b1;
            st_waddr = k_ff;
            st_wdata = sc_rd_ff;
            if (k_ff == hi_ff) begin
               if (stk_empty) begin
                  idx_in   = '0;
                  state_in = ST_ORD;
               end else begin
                  stk_ctl.pop = 1'b1;
                  state_in    = ST_SCHED;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_CRD;
            end
         end
         ST_ORD: begin
            st_re      = 1'b1;
            st_raddr_a = idx_ff;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if ({1'b0, idx_ff} == count_ff - 1'b1) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  cmp_in   = '0;
                  inv_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_ORD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         cmp_ff   <= '0;
         inv_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         cmp_ff   <= cmp_in;
         inv_ff   <= inv_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      lo_ff  <= lo_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
   end

   // Element memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_waddr] <= st_wdata;
      end
      if (st_re) begin
         st_rd_a_ff <= store_mem[st_raddr_a];
         st_rd_b_ff <= store_mem[st_raddr_b];
      end
   end

   // Scratch memory: merged elements, copied back after each merge.
   always_ff @(posedge clock) begin
      if (sc_we) begin
         scratch_mem[k_ff] <= sc_wdata;
      end
      if (sc_re) begin
         sc_rd_ff <= scratch_mem[k_ff];
      end
   end

   assign rsp_data = '{
      sorted_value: st_rd_a_ff,
      last_res:     ({1'b0, idx_ff} == count_ff - 1'b1),
      comparisons:  cmp_ff,
      inversions:   inv_ff,
      overflow:     ovf_ff
   };

   // A merge step always has an element to take, inside the range being merged.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MWR) |-> (avail_a || avail_b)) else $error("merge with both halves empty");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MWR) |-> (k_ff >= lo_ff && k_ff <= hi_ff)) else $error("merge index out of range");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS)) else $error("element count beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> ({1'b0, idx_ff} < count_ff)) else $error("result index beyond array");

endmodule
